// File: design/dslp_pkg.sv
// Shared types, constants and helpers for the joystick press classifier.
`timescale 1ns / 1ps

package dslp_pkg;

    // Register map (index = byte address / 4)
    localparam logic REG_DEBOUNCE_TICKS = 1'b0;
    localparam logic REG_LONG_TICKS     = 1'b1;

    // Register reset values
    localparam logic [15:0] DEBOUNCE_RESET = 16'd50;
    localparam logic [15:0] LONG_RESET     = 16'd1000;

    // Button codes
    localparam logic [2:0] BTN_NONE   = 3'd0;
    localparam logic [2:0] BTN_UP     = 3'd1;
    localparam logic [2:0] BTN_RIGHT  = 3'd2;
    localparam logic [2:0] BTN_DOWN   = 3'd3;
    localparam logic [2:0] BTN_LEFT   = 3'd4;
    localparam logic [2:0] BTN_CENTRE = 3'd5;

    localparam int NUM_LINES = 5;

    // One press result handed from the tracker to the output stage
    typedef struct packed {
        logic       valid;
        logic [2:0] button_code;
        logic       is_long;
    } press_t;

    // Priority pick: up, right, down, left, centre
    function automatic logic [2:0] first_high_line(input logic [NUM_LINES-1:0] levels);
        logic [2:0] code;
        code = BTN_NONE;
        if (levels[0])
            code = BTN_UP;
        else if (levels[1])
            code = BTN_RIGHT;
        else if (levels[2])
            code = BTN_DOWN;
        else if (levels[3])
            code = BTN_LEFT;
        else if (levels[4])
            code = BTN_CENTRE;
        return code;
    endfunction

endpackage

// File: design/dslp_tracker.sv
// Debounce and long-press countdowns, held button and press detection.
`timescale 1ns / 1ps

module dslp_tracker #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [dslp_pkg::NUM_LINES-1:0] line_levels,
    input  logic                          edge_seen,
    input  logic [15:0]                   debounce_ticks,
    input  logic [15:0]                   long_press_ticks,
    output dslp_pkg::press_t              press
);
    import dslp_pkg::*;

    logic [2:0]             held_reg, held_next;
    logic [COUNT_WIDTH-1:0] deb_cnt_reg, deb_cnt_next;
    logic                   deb_act_reg, deb_act_next;
    logic [COUNT_WIDTH-1:0] long_cnt_reg, long_cnt_next;
    logic                   long_act_reg, long_act_next;
    logic [COUNT_WIDTH-1:0] long_cnt_adv;
    logic                   long_act_adv;
    logic                   deb_expire;

    assign deb_expire = !edge_seen && deb_act_reg && (deb_cnt_reg <= COUNT_WIDTH'(1));

    // Next state for one tick
    always_comb
    begin
        // long-press countdown advances first
        long_cnt_adv = long_cnt_reg;
        long_act_adv = long_act_reg;
        if (long_act_reg)
        begin
            if (long_cnt_reg <= COUNT_WIDTH'(1))
            begin
                long_act_adv = 1'b0;
                long_cnt_adv = '0;
            end
            else
            begin
                long_cnt_adv = long_cnt_reg - COUNT_WIDTH'(1);
            end
        end

        long_cnt_next = long_cnt_adv;
        long_act_next = long_act_adv;
        deb_cnt_next  = deb_cnt_reg;
        deb_act_next  = deb_act_reg;
        held_next     = held_reg;
        press         = '0;

        if (edge_seen)
        begin
            deb_cnt_next = COUNT_WIDTH'(debounce_ticks);
            deb_act_next = 1'b1;
        end
        else if (deb_expire)
        begin
            deb_act_next = 1'b0;
            deb_cnt_next = '0;
            if (held_reg == BTN_NONE)
            begin
                // sample lines, start the hold timer
                long_cnt_next = COUNT_WIDTH'(long_press_ticks);
                long_act_next = 1'b1;
                held_next     = first_high_line(line_levels);
            end
            else
            begin
                // release: short if the hold timer still runs
                press.valid       = 1'b1;
                press.button_code = held_reg;
                press.is_long     = !long_act_adv;
                long_act_next     = 1'b0;
                if (long_act_adv)
                    long_cnt_next = '0;
                held_next = BTN_NONE;
            end
        end
        else if (deb_act_reg)
        begin
            deb_cnt_next = deb_cnt_reg - COUNT_WIDTH'(1);
        end
    end

    // State registers, updated once per accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg     <= BTN_NONE;
            deb_cnt_reg  <= '0;
            deb_act_reg  <= 1'b0;
            long_cnt_reg <= '0;
            long_act_reg <= 1'b0;
        end
        else if (step)
        begin
            held_reg     <= held_next;
            deb_cnt_reg  <= deb_cnt_next;
            deb_act_reg  <= deb_act_next;
            long_cnt_reg <= long_cnt_next;
            long_act_reg <= long_act_next;
        end
    end

endmodule

// File: design/dslp_out_stage.sv
// Result register on the master side of the stream.
`timescale 1ns / 1ps

module dslp_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  dslp_pkg::press_t press,
    output logic             slot_free,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [7:0]       m_axis_tdata,  // [2:0] button_code, [7:3] zero
    output logic [0:0]       m_axis_tuser   // [0] is_long
);
    import dslp_pkg::*;

    logic       valid_reg;
    logic [2:0] code_reg;
    logic       long_reg;

    assign slot_free = !valid_reg || m_axis_tready;

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (slot_free)
            valid_reg <= step && press.valid;
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (slot_free && step && press.valid)
        begin
            code_reg <= press.button_code;
            long_reg <= press.is_long;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {5'b0, code_reg};
    assign m_axis_tuser  = long_reg;

endmodule

// File: design/debounced_short_long_press_classifier_core.sv
// Top level: tick input register, config registers, tracker and result register.
//
//  Channel  | Dir | Contents
//  ---------+-----+-------------------------------------------------------
//  s_axis   | in  | one tick: line_levels, edge_seen
//  m_axis   | out | one press: button_code, is_long (tuser)
//  apb      | in  | reg 0 debounce_ticks @0x0, reg 1 long_press_ticks @0x4
//
// One tick request is taken per cycle while s_axis_tready is high; a press reaches m_axis
// through the input register, then the result register, once its tick is accepted.
// The only stall path is the result register: a held result that is not
// taken holds the input register, and s_axis_tready drops with it.
// Reset clears the counters, held button and both valid flags; registers
// return to 50 and 1000.
`timescale 1ns / 1ps

module debounced_short_long_press_classifier_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [4:0] line_levels, [5] edge_seen, [7:6] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [2:0] button_code, [7:3] zero
    output logic [0:0]  m_axis_tuser,   // [0] is_long
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dslp_pkg::*;

    logic [15:0]          debounce_ticks_reg;
    logic [15:0]          long_ticks_reg;
    logic                 in_valid_reg;
    logic [NUM_LINES-1:0] levels_reg;
    logic                 edge_reg;
    logic                 slot_free;
    logic                 step;
    logic                 cfg_write;
    press_t               press;

    // Config port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks_reg <= DEBOUNCE_RESET;
            long_ticks_reg     <= LONG_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_DEBOUNCE_TICKS: debounce_ticks_reg <= pwdata[15:0];
                REG_LONG_TICKS:     long_ticks_reg     <= pwdata[15:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_DEBOUNCE_TICKS: prdata = {16'b0, debounce_ticks_reg};
            REG_LONG_TICKS:     prdata = {16'b0, long_ticks_reg};
            default:            prdata = '0;
        endcase
    end

    // Input register: the tick is processed when the result slot is free
    assign step          = in_valid_reg && slot_free;
    assign s_axis_tready = !in_valid_reg || slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            levels_reg <= s_axis_tdata[NUM_LINES-1:0];
            edge_reg   <= s_axis_tdata[5];
        end
    end

    dslp_tracker #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_tracker (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (step),
        .line_levels      (levels_reg),
        .edge_seen        (edge_reg),
        .debounce_ticks   (debounce_ticks_reg),
        .long_press_ticks (long_ticks_reg),
        .press            (press)
    );

    dslp_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .press         (press),
        .slot_free     (slot_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// File: test/debounced_short_long_press_classifier_core_test.sv
// Self-checking testbench for the joystick short/long press classifier core.
`timescale 1ns / 1ps

module debounced_short_long_press_classifier_core_test;

    import dslp_pkg::*;

    localparam logic PRESS_SHORT = 1'b0;
    localparam logic PRESS_LONG  = 1'b1;
    // Directed rows: expectation typed in, or taken from the press predictor
    localparam logic TYPED = 1'b1;
    localparam logic PRED  = 1'b0;

    typedef struct packed {
        logic [2:0] code;
        logic       is_long;
    } press_rec_t;

    typedef struct packed {
        logic [4:0] levels;
        logic       edge_seen;
        logic       typed;
        logic       press;
        logic [2:0] code;
        logic       is_long;
    } tick_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // [4:0] line_levels, [5] edge_seen, [7:6] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // [2:0] button_code, [7:3] zero
    logic [0:0]  m_axis_tuser;         // [0] is_long
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    debounced_short_long_press_classifier_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #2 clk = ~clk;

    // Predictor copy of registers and tracker state
    logic [15:0] cfg_debounce = DEBOUNCE_RESET;
    logic [15:0] cfg_long     = LONG_RESET;
    logic [2:0]  held = BTN_NONE;
    logic [15:0] bounce_left = '0;
    logic        bounce_run = 1'b0;
    logic [15:0] long_left = '0;
    logic        long_run = 1'b0;

    press_rec_t  pending_presses [$];
    int          mismatches = 0;
    int          ticks_sent = 0;
    int          presses_seen = 0;
    int          long_seen = 0;
    int          settings_used = 0;
    bit          calm = 1'b0;      // no idling on either side while set
    bit          held_off = 1'b0;

    // Directed ticks; debounce 0 and long press 3 are loaded beforehand
    tick_row_t directed_rows [28] = '{
        // up pressed, released one tick later: short
        '{5'h01, 1'b1, PRED,  1'b0, BTN_NONE,  PRESS_SHORT},
        '{5'h01, 1'b0, PRED,  1'b0, BTN_NONE,  PRESS_SHORT},
        '{5'h00, 1'b1, PRED,  1'b0, BTN_NONE,  PRESS_SHORT},
        '{5'h00, 1'b0, TYPED, 1'b1, BTN_UP,    PRESS_SHORT},
        // right held until the long countdown runs out: long
        '{5'h02, 1'b1, PRED,  1'b0, BTN_NONE,  PRESS_SHORT},
        '{5'h02, 1'b0, PRED,  1'b0, BTN_NONE,  PRESS_SHORT},
        '{5'h02, 1'b0, PRED,  1'b0, BTN_NONE,  PRESS_SHORT},
        '{5'h02, 1'b0, PRED,  1'b0, BTN_NONE,  PRESS_SHORT},
        '{5'h02, 1'b0, PRED,  1'b0, BTN_NONE,  PRESS_SHORT},
        '{5'h00, 1'b1, PRED,  1'b0, BTN_NONE,  PRESS_SHORT},
        '{5'h00, 1'b0, TYPED, 1'b1, BTN_RIGHT, PRESS_LONG},
        // all lines high: up wins
        '{5'h1f, 1'b1, PRED,  1'b0, BTN_NONE,  PRESS_SHORT},
        '{5'h1f, 1'b0, PRED,  1'b0, BTN_NONE,  PRESS_SHORT},
        '{5'h00, 1'b1, PRED,  1'b0, BTN_NONE,  PRESS_SHORT},
        '{5'h00, 1'b0, TYPED, 1'b1, BTN_UP,    PRESS_SHORT},
        // down, left and centre high: down wins
        '{5'h1c, 1'b1, PRED,  1'b0, BTN_NONE,  PRESS_SHORT},
        '{5'h1c, 1'b0, PRED,  1'b0, BTN_NONE,  PRESS_SHORT},
        '{5'h00, 1'b1, PRED,  1'b0, BTN_NONE,  PRESS_SHORT},
        '{5'h00, 1'b0, TYPED, 1'b1, BTN_DOWN,  PRESS_SHORT},
        // centre; long countdown ends in the release tick, so long
        '{5'h10, 1'b1, PRED,  1'b0, BTN_NONE,  PRESS_SHORT},
        '{5'h10, 1'b0, PRED,  1'b0, BTN_NONE,  PRESS_SHORT},
        '{5'h00, 1'b0, PRED,  1'b0, BTN_NONE,  PRESS_SHORT},
        '{5'h00, 1'b1, PRED,  1'b0, BTN_NONE,  PRESS_SHORT},
        '{5'h00, 1'b0, TYPED, 1'b1, BTN_CENTRE, PRESS_LONG},
        // no line high at sampling: nothing held, never a press
        '{5'h00, 1'b1, PRED,  1'b0, BTN_NONE,  PRESS_SHORT},
        '{5'h00, 1'b0, PRED,  1'b0, BTN_NONE,  PRESS_SHORT},
        '{5'h00, 1'b1, PRED,  1'b0, BTN_NONE,  PRESS_SHORT},
        '{5'h00, 1'b0, PRED,  1'b0, BTN_NONE,  PRESS_SHORT}
    };

    // Random phases: debounce, long press, tick count
    int unsigned phase_debounce [7] = '{1, 0, 3, 2, 5, 65535, 1};
    int unsigned phase_long     [7] = '{4, 1, 12, 30, 8, 65535, 0};
    int unsigned phase_ticks    [7] = '{400, 300, 400, 350, 300, 40, 160};

    function automatic logic [2:0] priority_button(input logic [4:0] levels);
        for (int i = 0; i < 5; i++)
            if (levels[i])
                return 3'(i + 1);
        return BTN_NONE;
    endfunction

    // One tick of the press tracker
    function automatic void step_classifier(input logic [4:0] levels, input logic edge_seen,
                                            output logic got, output press_rec_t rec);
        got = 1'b0;
        rec = '0;
        if (long_run)
        begin
            if (long_left <= 16'd1)
            begin
                long_run = 1'b0;
                long_left = '0;
            end
            else
                long_left = long_left - 16'd1;
        end
        if (edge_seen)
        begin
            bounce_left = cfg_debounce;
            bounce_run = 1'b1;
        end
        else if (bounce_run)
        begin
            if (bounce_left <= 16'd1)
            begin
                bounce_run = 1'b0;
                bounce_left = '0;
                if (held == BTN_NONE)
                begin
                    long_left = cfg_long;
                    long_run = 1'b1;
                    held = priority_button(levels);
                end
                else
                begin
                    rec.code = held;
                    rec.is_long = long_run ? PRESS_SHORT : PRESS_LONG;
                    long_run = 1'b0;
                    long_left = '0;
                    held = BTN_NONE;
                    got = 1'b1;
                end
            end
            else
                bounce_left = bounce_left - 16'd1;
        end
    endfunction

    task automatic apb_access(input logic wr, input logic idx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        rdata = prdata;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_reg(input logic idx, input logic [15:0] want);
        logic [31:0] got;
        apb_access(1'b0, idx, '0, got);
        if (got !== {16'd0, want})
        begin
            mismatches++;
            $display("%0t: reg %0d read: expected %0d, actual %0d", $time, idx, want, got);
        end
    endtask

    task automatic write_cfg(input logic idx, input logic [15:0] value);
        logic [31:0] unused;
        apb_access(1'b1, idx, {16'd0, value}, unused);
        if (idx == REG_DEBOUNCE_TICKS)
            cfg_debounce = value;
        else
            cfg_long = value;
        check_reg(idx, value);
    endtask

    // Offer one tick request, wait for it to be taken, record any press it causes
    task automatic send_tick(input logic [4:0] levels, input logic edge_seen, input logic typed,
                             input logic press, input logic [2:0] code, input logic is_long);
        logic       got;
        press_rec_t rec;
        while (!calm && $urandom_range(99) < 38)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, edge_seen, levels};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        step_classifier(levels, edge_seen, got, rec);
        if (typed)
        begin
            got = press;
            rec.code = code;
            rec.is_long = is_long;
        end
        if (got)
            pending_presses.push_back(rec);
        ticks_sent++;
    endtask

    // Stop offering and let the block settle before touching registers
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_presses.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic run_phase(input int unsigned dbn, input int unsigned lng,
                             input int unsigned count);
        int          start;
        int unsigned bounces;
        int unsigned span;
        int unsigned quiet;
        logic [4:0]  lv;
        write_cfg(REG_DEBOUNCE_TICKS, dbn[15:0]);
        write_cfg(REG_LONG_TICKS, lng[15:0]);
        settings_used++;
        start = ticks_sent;
        while (ticks_sent - start < count)
        begin
            if ($urandom_range(99) < 85)
            begin
                // contact bounce, then a stable level
                case ($urandom_range(4))
                    0:       lv = '0;
                    1, 2:    lv = 5'b1 << $urandom_range(4);
                    default: lv = 5'($urandom_range(31));
                endcase
                bounces = $urandom_range(1, 3);
                repeat (bounces - 1)
                    send_tick(5'($urandom_range(31)), 1'b1, PRED, 1'b0, BTN_NONE,
                              PRESS_SHORT);
                send_tick(lv, 1'b1, PRED, 1'b0, BTN_NONE, PRESS_SHORT);
                if ($urandom_range(99) < 70)
                    span = dbn + 2;
                else
                    span = dbn + lng + 3;
                if (span > 120)
                    span = 120;   // keep stretches short under large settings
                quiet = $urandom_range(0, span);
                repeat (quiet)
                    send_tick(lv, 1'b0, PRED, 1'b0, BTN_NONE, PRESS_SHORT);
            end
            else
                send_tick(5'($urandom_range(31)), 1'($urandom_range(1)), PRED, 1'b0,
                          BTN_NONE, PRESS_SHORT);
        end
        drain();
    endtask

    // Press receiver and checker
    initial
    begin
        int         hold_left;
        press_rec_t want;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_presses.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected press: expected none, actual code %0d long %0b",
                             $time, m_axis_tdata[2:0], m_axis_tuser[0]);
                end
                else
                begin
                    want = pending_presses.pop_front();
                    if (m_axis_tdata[2:0] !== want.code)
                    begin
                        mismatches++;
                        $display("%0t: button_code: expected %0d, actual %0d",
                                 $time, want.code, m_axis_tdata[2:0]);
                    end
                    if (m_axis_tuser[0] !== want.is_long)
                    begin
                        mismatches++;
                        $display("%0t: is_long: expected %0b, actual %0b",
                                 $time, want.is_long, m_axis_tuser[0]);
                    end
                    if (want.is_long)
                        long_seen++;
                end
                presses_seen++;
            end
            // one long back-pressure window early in the run
            if (!held_off && presses_seen == 10)
            begin
                held_off = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (calm)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(99) >= 38);
        end
    end

    // Main sequence
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        check_reg(REG_DEBOUNCE_TICKS, DEBOUNCE_RESET);
        check_reg(REG_LONG_TICKS, LONG_RESET);

        // directed ticks with a zero debounce setting
        write_cfg(REG_DEBOUNCE_TICKS, 16'd0);
        write_cfg(REG_LONG_TICKS, 16'd3);
        settings_used++;
        foreach (directed_rows[i])
            send_tick(directed_rows[i].levels, directed_rows[i].edge_seen,
                      directed_rows[i].typed, directed_rows[i].press,
                      directed_rows[i].code, directed_rows[i].is_long);
        drain();

        for (int p = 0; p < 7; p++)
        begin
            calm = (p == 2);
            run_phase(phase_debounce[p], phase_long[p], phase_ticks[p]);
        end
        calm = 1'b0;

        $display("Run covered %0d ticks under %0d register settings, including 0 and 65535.",
                 ticks_sent, settings_used);
        $display("Presses checked: %0d, of them %0d long; %0d mismatches.",
                 presses_seen, long_seen, mismatches);
        if (mismatches == 0)
            $display("debounced_short_long_press_classifier_core verification clean");
        else
            $display("debounced_short_long_press_classifier_core verification failed");
        $finish;
    end

    // Timeout
    initial
    begin
        #2_000_000;
        $display("debounced_short_long_press_classifier_core verification failed");
        $finish;
    end

endmodule
